[rtl/core/bitmap_block_allocator_unit_assert.svh]
// Assertion macros used by the allocator checker file.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/core/bba_pkg.sv]
// Package: field widths, codes, control structs and the row mask helper.
`default_nettype none
package bba_pkg;

  // Field widths
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // Map word geometry: one row holds 64 block bits, bit j is block row*64+j
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;
  localparam int unsigned LIM_W  = 17;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FORMAT  = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;
  localparam logic [CNT_W-1:0]     TOTAL_RST    = 13'd4096;
  localparam logic [CNT_W-1:0]     RESERVED_RST = 13'd0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic row_clr;    // rewind the row counter
    logic rd_next;    // read the row counter's row, then advance
    logic rd_idx;     // read the row that holds block_index
    logic sweep_wr;   // write the row counter's row with a fill pattern, then advance
    logic sweep_fmt;  // fill pattern follows the reserved count (else all free)
    logic res_none;   // result: no free block
    logic res_range;  // result: block beyond total
    logic alloc_done; // mark the found bit, result ok
    logic rmw_done;   // finish release or query on the read row
    logic fmt_done;   // set the free count after format
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             no_free;    // count is zero or no block in range
    logic             out_range;  // block_index at or above total
    logic             found;      // evaluated row has a free bit in range
    logic             eval_last;  // evaluated row is the last one in range
    logic             sweep_last; // row counter sits on the last map row
    logic             out_free;   // output register can take a word
  } sts_t;

  // Ones for the blocks of the row at base that lie below limit
  function automatic logic [WORD_W-1:0] row_mask(input logic [LIM_W-1:0] limit,
                                                 input logic [LIM_W-1:0] base);
    logic [LIM_W-1:0] span;
    span = limit - base;
    if (limit <= base) begin
      return '0;
    end else if (span >= LIM_W'(WORD_W)) begin
      return '1;
    end else begin
      return (WORD_W'(1) << span[BIT_W-1:0]) - WORD_W'(1);
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/bba_ctrl.sv]
// Controller: sequences each action and the clearing pass after reset.
`default_nettype none
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RMW   = 3'd4;
  localparam logic [2:0] S_FMT   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  // Take a word only when idle
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.row_clr = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        case (sts_i.act)
          ACT_ALLOC: begin
            if (sts_i.no_free) begin
              cmd_o.res_none = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.rd_next = 1'b1;
              state_d       = S_SCAN;
            end
          end
          ACT_RELEASE, ACT_QUERY: begin
            if (sts_i.out_range) begin
              cmd_o.res_range = 1'b1;
              state_d         = S_DONE;
            end else begin
              cmd_o.rd_idx = 1'b1;
              state_d      = S_RMW;
            end
          end
          default: begin
            state_d = S_FMT;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.found) begin
          cmd_o.alloc_done = 1'b1;
          state_d          = S_DONE;
        end else if (sts_i.eval_last) begin
          cmd_o.res_none = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_RMW: begin
        cmd_o.rmw_done = 1'b1;
        state_d        = S_DONE;
      end
      S_FMT: begin
        cmd_o.sweep_wr  = 1'b1;
        cmd_o.sweep_fmt = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.fmt_done = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bba_dp.sv]
// Datapath: usage map memory, row scan, free count, config and output registers.
`default_nettype none
module bba_dp
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic [ACT_W-1:0]     in_action_i,
  input  wire logic [IDX_W-1:0]     in_block_index_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CNT_W-1:0]     cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ST_W-1:0]           out_status_o,
  output logic [IDX_W-1:0]          out_granted_block_o,
  output logic                      out_bit_value_o,
  output logic [CNT_W-1:0]          out_free_left_o
);

  localparam int unsigned ROWS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CAP  = (MAX_BLOCKS < 8191) ? MAX_BLOCKS : 8191;

  // Configuration and live state
  logic [CNT_W-1:0] total_q, reserved_q, free_cnt_q;
  logic [ACT_W-1:0] act_q;
  logic [IDX_W-1:0] idx_q;
  logic [RW-1:0]    row_q, eval_row_q;
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] mem [ROWS];

  // Result and output registers
  logic [ST_W-1:0]  res_status_q;
  logic [IDX_W-1:0] res_granted_q;
  logic             res_bit_q;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_status_q;
  logic [IDX_W-1:0] out_granted_q;
  logic             out_bit_q;
  logic [CNT_W-1:0] out_free_q;

  // Effective total and reserved count
  logic [CNT_W-1:0] eff_total, eff_m1, res_eff;
  assign eff_total = (total_q > CNT_W'(CAP)) ? CNT_W'(CAP) : total_q;
  assign eff_m1    = eff_total - CNT_W'(1);
  assign res_eff   = (reserved_q < eff_total) ? reserved_q : eff_total;

  // Row numbers derived from block numbers
  logic [15:0]   idx_row_w, last_row_w;
  logic [RW-1:0] idx_row, last_row;
  assign idx_row_w  = 16'(idx_q[IDX_W-1:BIT_W]);
  assign last_row_w = 16'(eff_m1[CNT_W-1:BIT_W]);
  assign idx_row    = idx_row_w[RW-1:0];
  assign last_row   = last_row_w[RW-1:0];

  // Evaluate the read row: free bits below the total, lowest one wins
  logic [LIM_W-1:0]  eval_base, sweep_base, sweep_lim, grant_w;
  logic [WORD_W-1:0] free_vec, fill_word, bit_sel;
  logic [BIT_W-1:0]  pos;
  logic              found;
  assign eval_base = LIM_W'(eval_row_q) << BIT_W;
  assign free_vec  = ~rdata_q & row_mask(LIM_W'(eff_total), eval_base);
  assign found     = |free_vec;

  always_comb begin
    pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        pos = BIT_W'(j);
      end
    end
  end

  assign grant_w = eval_base | LIM_W'(pos);

  // Fill pattern for format and the clearing pass
  assign sweep_base = LIM_W'(row_q) << BIT_W;
  assign sweep_lim  = cmd_i.sweep_fmt ? LIM_W'(res_eff) : '0;
  assign fill_word  = row_mask(sweep_lim, sweep_base);
  assign bit_sel    = WORD_W'(1) << idx_q[BIT_W-1:0];

  // Memory port control
  logic              mem_we, mem_re;
  logic [RW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = row_q;
    wr_data = fill_word;
    if (cmd_i.sweep_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.alloc_done) begin
      mem_we  = 1'b1;
      wr_addr = eval_row_q;
      wr_data = rdata_q | (WORD_W'(1) << pos);
    end else if (cmd_i.rmw_done && (act_q == ACT_RELEASE)) begin
      mem_we  = 1'b1;
      wr_addr = eval_row_q;
      wr_data = rdata_q & ~bit_sel;
    end
  end

  assign mem_re  = cmd_i.rd_next | cmd_i.rd_idx;
  assign rd_addr = cmd_i.rd_idx ? idx_row : row_q;

  // Map memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Capture the item, track rows, build the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_action_i;
      idx_q <= in_block_index_i;
    end
    if (mem_re) begin
      eval_row_q <= rd_addr;
    end
    if (cmd_i.res_none) begin
      res_status_q  <= ST_NONE;
      res_granted_q <= '0;
      res_bit_q     <= 1'b0;
    end else if (cmd_i.res_range) begin
      res_status_q  <= ST_RANGE;
      res_granted_q <= '0;
      res_bit_q     <= 1'b0;
    end else if (cmd_i.alloc_done) begin
      res_status_q  <= ST_OK;
      res_granted_q <= grant_w[IDX_W-1:0];
      res_bit_q     <= 1'b0;
    end else if (cmd_i.rmw_done) begin
      res_status_q  <= ST_OK;
      res_granted_q <= '0;
      res_bit_q     <= (act_q == ACT_QUERY) ? rdata_q[idx_q[BIT_W-1:0]] : 1'b0;
    end else if (cmd_i.fmt_done) begin
      res_status_q  <= ST_OK;
      res_granted_q <= '0;
      res_bit_q     <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_granted_q <= res_granted_q;
      out_bit_q     <= res_bit_q;
      out_free_q    <= free_cnt_q;
    end
  end

  // Row counter, free count, config registers, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      free_cnt_q  <= '0;
      total_q     <= TOTAL_RST;
      reserved_q  <= RESERVED_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.row_clr) begin
        row_q <= '0;
      end else if (cmd_i.rd_next || cmd_i.sweep_wr) begin
        row_q <= row_q + RW'(1);
      end
      if (cmd_i.alloc_done) begin
        free_cnt_q <= free_cnt_q - CNT_W'(1);
      end else if (cmd_i.rmw_done && (act_q == ACT_RELEASE) && (free_cnt_q < eff_total)) begin
        free_cnt_q <= free_cnt_q + CNT_W'(1);
      end else if (cmd_i.fmt_done) begin
        free_cnt_q <= eff_total - res_eff;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TOTAL:    total_q    <= cfg_data_i;
          CFG_RESERVED: reserved_q <= cfg_data_i;
          default:      total_q    <= total_q;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.act        = act_q;
    sts_o.no_free    = (free_cnt_q == '0) || (eff_total == '0);
    sts_o.out_range  = (CNT_W'(idx_q) >= eff_total);
    sts_o.found      = found;
    sts_o.eval_last  = (eval_row_q == last_row);
    sts_o.sweep_last = (row_q == RW'(ROWS - 1));
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_granted_block_o = out_granted_q;
  assign out_bit_value_o     = out_bit_q;
  assign out_free_left_o     = out_free_q;

endmodule
`default_nettype wire

[rtl/core/bitmap_block_allocator_unit.sv]
// Top level: bitmap block allocator, controller plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid / stall   | action, block_index
//  out     | output    | out_valid / stall  | status, granted_block, bit_value,
//          |           |                    | free_left
//  cfg     | input     | cfg_valid / ready  | index (0 total, 1 reserved), data
//
// Allocate scans the map rows in order (64 blocks a row, at most MAX_BLOCKS/64)
// and stops at the first row with a free bit; one row is read from the map memory each cycle.
// Release reads then writes one row, query only reads one row; format writes
// all MAX_BLOCKS/64 rows, one row written each cycle.
// After reset a clearing pass writes all MAX_BLOCKS/64 rows before the first
// word is taken; config writes are always ready.
// A stalled output holds its word; the next input word is taken meanwhile.
`default_nettype none
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ACT_W-1:0]     in_action_i,
  input  wire logic [IDX_W-1:0]     in_block_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ST_W-1:0]           out_status_o,
  output logic [IDX_W-1:0]          out_granted_block_o,
  output logic                      out_bit_value_o,
  output logic [CNT_W-1:0]          out_free_left_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CNT_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Config writes are always ready and are registered directly
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_action_i         (in_action_i),
    .in_block_index_i    (in_block_index_i),
    .cfg_valid_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_granted_block_o (out_granted_block_o),
    .out_bit_value_o     (out_bit_value_o),
    .out_free_left_o     (out_free_left_o)
  );

endmodule
`default_nettype wire

[rtl/core/bba_checker.sv]
// Port checker for the allocator top level, with its bind.
`default_nettype none
`include "bitmap_block_allocator_unit_assert.svh"
module bba_checker
  import bba_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [ST_W-1:0]      out_status_o,
  input wire logic [IDX_W-1:0]     out_granted_block_o,
  input wire logic                 out_bit_value_o,
  input wire logic [CNT_W-1:0]     out_free_left_o
);

  // Busy right after taking a word
  `BBA_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Only defined status codes leave the block
  `BBA_ASSERT_IMP(a_status_code, out_valid_o,
    out_status_o == ST_OK || out_status_o == ST_NONE || out_status_o == ST_RANGE)

  // Failed actions carry no grant and no bit
  `BBA_ASSERT_IMP(a_fail_fields_zero, out_valid_o && out_status_o != ST_OK,
    out_granted_block_o == '0 && out_bit_value_o == 1'b0)

  // Stalled result word holds its valid, status and free count
  `BBA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_status_o) && $stable(out_free_left_o))

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);
`default_nettype wire
